// File: sv/biq_pkg.sv
// Shared constants for the two-pole two-zero IIR filter.
// Holds default widths, the configuration register indexes and the stream
// packing widths. No dependencies.
package biq_pkg;

  localparam int SAMPLE_WIDTH_DEF   = 24;
  localparam int COEF_FRAC_BITS_DEF = 22;
  localparam int STATE_WIDTH_DEF    = 48;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_B1 = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_B2 = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_A1 = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_A2 = 2'd3;

  // Number of bits a field of width w takes on tdata, padded to bytes.
  function automatic int byte_pad(input int w);
    return ((w + 7) / 8) * 8;
  endfunction

endpackage

// File: sv/biq_mac.sv
// Three-term multiply-accumulate with round-half-up and saturation.
// Computes sat(((base << F) + c1*h1 + c2*h2 + 2^(F-1)) >>> F) to SAT_W bits.
// Depends on biq_pkg for default widths.
module biq_mac
  import biq_pkg::*;
#(
  parameter int BASE_W = SAMPLE_WIDTH_DEF,
  parameter int SAT_W  = SAMPLE_WIDTH_DEF,
  parameter int FRAC_W = COEF_FRAC_BITS_DEF,
  parameter int STW    = STATE_WIDTH_DEF
) (
  input  logic signed [BASE_W-1:0] base,
  input  logic signed [FRAC_W+1:0] c1,
  input  logic signed [STW-1:0]    h1,
  input  logic signed [FRAC_W+1:0] c2,
  input  logic signed [STW-1:0]    h2,
  output logic signed [SAT_W-1:0]  res,
  output logic                     clip
);

  localparam int CW = FRAC_W + 2;
  localparam int PW = CW + STW;
  localparam int AW = PW + 2;
  localparam int RW = AW - FRAC_W;
  localparam logic signed [AW-1:0] RND = AW'(1) << (FRAC_W - 1);

  logic signed [PW-1:0]            p1;
  logic signed [PW-1:0]            p2;
  logic signed [BASE_W+FRAC_W-1:0] base_sh;
  logic signed [AW-1:0]            acc;
  logic signed [AW-1:0]            acc_sh;
  logic signed [RW-1:0]            rnd;
  logic [RW-SAT_W:0]               upper;
  logic                            ovf;

  assign p1      = c1 * h1;
  assign p2      = c2 * h2;
  assign base_sh = $signed({base, {FRAC_W{1'b0}}});
  assign acc     = AW'(base_sh) + AW'(p1) + AW'(p2) + RND;
  assign acc_sh  = acc >>> FRAC_W;
  assign rnd     = acc_sh[RW-1:0];

  // The value fits when every bit from the target sign bit up agrees.
  assign upper = rnd[RW-1:SAT_W-1];
  assign ovf   = !((&upper) || !(|upper));
  assign clip  = ovf;
  assign res   = ovf ? {rnd[RW-1], {(SAT_W-1){~rnd[RW-1]}}} : rnd[SAT_W-1:0];

endmodule

// File: sv/two_pole_two_zero_iir_filter_top.sv
// Top level of the two-pole two-zero IIR filter: stream ports, coefficient
// registers, history registers and the two arithmetic units.
// Depends on biq_pkg and biq_mac.
//
//   Channel | Direction | Payload
//   in_     | sink      | tdata: sample; tuser: first_sample
//   out_    | source    | tdata: filtered; tuser: clipped
//   cfg_    | write     | cfg_addr selects coef_b1, coef_b2, coef_a1, coef_a2
//
// One sample per cycle is sustained unless the output stalls; an accepted
// sample moves from the input register to the result register. Reset is
// synchronous and clears the pipeline, coefficients and history. A stalled
// output holds the result while one more sample waits in the input register.
module two_pole_two_zero_iir_filter_top
  import biq_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  parameter int STATE_WIDTH    = STATE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [byte_pad(SAMPLE_WIDTH)-1:0]   in_tdata,   // sample
  input  logic                                in_tuser,   // first_sample
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [byte_pad(SAMPLE_WIDTH)-1:0]   out_tdata,  // filtered
  output logic                                out_tuser,  // clipped
  input  logic                                cfg_wen,
  input  logic [CFG_ADDR_W-1:0]               cfg_addr,
  input  logic [COEF_FRAC_BITS+1:0]           cfg_wdata
);

  localparam int CW = COEF_FRAC_BITS + 2;
  localparam int TW = byte_pad(SAMPLE_WIDTH);

  logic signed [CW-1:0] coef_b1_r, coef_b2_r, coef_a1_r, coef_a2_r;
  logic signed [STATE_WIDTH-1:0] hist0_r, hist1_r, hist2_r;
  logic signed [STATE_WIDTH-1:0] h0, h1, h2;

  logic                           in_vld_r;
  logic signed [SAMPLE_WIDTH-1:0] in_sample_r;
  logic                           in_first_r;

  logic                           out_vld_r;
  logic signed [SAMPLE_WIDTH-1:0] out_filt_r;
  logic                           out_clip_r;

  logic                           advance;
  logic signed [SAMPLE_WIDTH-1:0] y_nxt;
  logic signed [STATE_WIDTH-1:0]  hist0_nxt;
  logic                           clip_y, clip_h;

  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  // A first sample sees an all-zero history.
  assign h0 = in_first_r ? '0 : hist0_r;
  assign h1 = in_first_r ? '0 : hist1_r;
  assign h2 = in_first_r ? '0 : hist2_r;

  biq_mac #(
    .BASE_W(STATE_WIDTH), .SAT_W(SAMPLE_WIDTH),
    .FRAC_W(COEF_FRAC_BITS), .STW(STATE_WIDTH)
  ) u_mac_out (
    .base(h0), .c1(coef_a1_r), .h1(h1), .c2(coef_a2_r), .h2(h2),
    .res(y_nxt), .clip(clip_y)
  );

  // The new newest value uses the shifted history: old h0 and old h1.
  biq_mac #(
    .BASE_W(SAMPLE_WIDTH), .SAT_W(STATE_WIDTH),
    .FRAC_W(COEF_FRAC_BITS), .STW(STATE_WIDTH)
  ) u_mac_hist (
    .base(in_sample_r), .c1(coef_b1_r), .h1(h0), .c2(coef_b2_r), .h2(h1),
    .res(hist0_nxt), .clip(clip_h)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_b1_r <= '0;
      coef_b2_r <= '0;
      coef_a1_r <= '0;
      coef_a2_r <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        REG_COEF_B1: coef_b1_r <= cfg_wdata;
        REG_COEF_B2: coef_b2_r <= cfg_wdata;
        REG_COEF_A1: coef_a1_r <= cfg_wdata;
        REG_COEF_A2: coef_a2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      hist0_r   <= '0;
      hist1_r   <= '0;
      hist2_r   <= '0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        hist0_r   <= hist0_nxt;
        hist1_r   <= h0;
        hist2_r   <= h1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_sample_r <= in_tdata[SAMPLE_WIDTH-1:0];
      in_first_r  <= in_tuser;
    end
    if (advance) begin
      out_filt_r <= y_nxt;
      out_clip_r <= clip_y || clip_h;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = TW'($unsigned(out_filt_r));
  assign out_tuser  = out_clip_r;

endmodule

// File: sv/biq_checker.sv
// Port-level checker for the IIR filter top level, bound to every instance.
// Depends on biq_pkg and two_pole_two_zero_iir_filter_top.
module biq_checker
  import biq_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [byte_pad(SAMPLE_WIDTH)-1:0] in_tdata,
  input logic                              in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [byte_pad(SAMPLE_WIDTH)-1:0] out_tdata,
  input logic                              out_tuser,
  input logic                              cfg_wen,
  input logic [CFG_ADDR_W-1:0]             cfg_addr,
  input logic [COEF_FRAC_BITS+1:0]         cfg_wdata
);

  // No result may appear straight out of reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // The input only stalls when a result is held and the sink is stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled while output side is free");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)
      && $stable(out_tuser)))
    else $error("stalled result changed or dropped");

  // A waiting input transaction keeps its payload until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && !in_tready) |=> (in_tvalid && $stable(in_tdata)
      && $stable(in_tuser)))
    else $error("waiting input changed or dropped");

  // Coefficients are written only while the stream is idle.
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wen |-> (!in_tvalid && !out_tvalid && !$isunknown({cfg_addr, cfg_wdata})))
    else $error("coefficient write while samples are in flight");

endmodule

bind two_pole_two_zero_iir_filter_top biq_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS)
) u_biq_checker (.*);
